// ===== rtl/core/eth_ip_tcp_payload_extractor_core_defines.svh =====
// Assertion macros for the payload extractor checks
`ifndef ETH_IP_TCP_PAYLOAD_EXTRACTOR_CORE_DEFINES_SVH
`define ETH_IP_TCP_PAYLOAD_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication, quiet in reset
`define EITPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet in reset
`define EITPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define EITPE_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/eitpe_pkg.sv =====
// Shared types and constants for the Ethernet/IP/TCP payload extractor
package eitpe_pkg;

  localparam int POS_W = 17;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_first;
    logic        frame_last;
    logic [15:0] frame_size;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [3:0]  status;
    logic        ip_version_six;
    logic [63:0] source_addr_high;
    logic [63:0] source_addr_low;
    logic [15:0] payload_length;
  } out_item_t;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_NOT_IP    = 4'd2;
  localparam logic [3:0] ST_NOT_TCP   = 4'd3;
  localparam logic [3:0] ST_IP_LEN    = 4'd4;
  localparam logic [3:0] ST_IHL_LEN   = 4'd5;
  localparam logic [3:0] ST_IP_PAY    = 4'd6;
  localparam logic [3:0] ST_TCP_HDR   = 4'd7;
  localparam logic [3:0] ST_BAD_HLEN  = 4'd8;
  localparam logic [3:0] ST_EARLY_END = 4'd9;

  localparam logic [15:0] MIN_FRAME  = 16'd54;
  localparam logic [15:0] ETYPE_IP4  = 16'h0800;
  localparam logic [15:0] ETYPE_IP6  = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [POS_W-1:0] ETH_HDR   = 17'd14;
  localparam logic [POS_W-1:0] ETH_IP6   = 17'd54;
  localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;
  localparam logic [POS_W-1:0] DOFF_OFS  = 17'd12;
  localparam logic [15:0]      TCP_MIN   = 16'd20;

endpackage

// ===== rtl/core/eitpe_in_stage.sv =====
// Input register stage for frame bytes
module eitpe_in_stage
  import eitpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     advance,
  output logic     s1_valid,
  output in_item_t s1_item
);

  logic     valid_r;
  in_item_t item_r;

  assign in_stall = valid_r && !advance;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== rtl/core/eitpe_parser.sv =====
// Frame parse state and per-byte verdict / payload logic
module eitpe_parser
  import eitpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  in_item_t  s1_item,
  input  logic      advance,
  output logic      res_valid,
  output out_item_t res_item
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ETH     = 3'd1;
  localparam logic [2:0] PH_IP4     = 3'd2;
  localparam logic [2:0] PH_IP6     = 3'd3;
  localparam logic [2:0] PH_TCPHDR  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [POS_W-1:0] pos_r, pos_b, pos_nxt;
  logic [15:0]      size_r, size_b, size_nxt;
  logic [2:0]       phase_r, phase_b, phase_nxt;
  logic [15:0]      etype_r, etype_b, etype_nxt;
  logic [6:0]       ihl_r, ihl_b, ihl_nxt;
  logic [15:0]      iplen_r, iplen_b, iplen_nxt;
  logic [63:0]      ahi_r, ahi_b, ahi_nxt;
  logic [63:0]      alo_r, alo_b, alo_nxt;
  logic [POS_W-1:0] start_r, start_b, start_nxt;
  logic [POS_W-1:0] end_r, end_b, end_nxt;

  logic             step;
  logic [7:0]       b;
  logic             hit;
  logic [3:0]       st;
  logic [15:0]      etype_c;
  logic [15:0]      ihl_ext;
  logic [3:0]       doff;
  logic [15:0]      doff4;
  logic [15:0]      avail;
  logic             fin;

  function automatic out_item_t mk_verdict(input logic [3:0] code, input logic six,
                                           input logic ok, input logic [63:0] hi,
                                           input logic [63:0] lo, input logic [15:0] len);
    out_item_t v;
    v                  = '0;
    v.result_kind      = KIND_VERDICT;
    v.status           = code;
    v.ip_version_six   = six;
    v.source_addr_high = ok ? hi : 64'd0;
    v.source_addr_low  = ok ? lo : 64'd0;
    v.payload_length   = ok ? len : 16'd0;
    return v;
  endfunction

  assign step = s1_valid && advance;
  assign b    = s1_item.data_byte;

  always_comb begin
    if (s1_item.frame_first) begin
      pos_b   = '0;
      size_b  = s1_item.frame_size;
      phase_b = PH_ETH;
      etype_b = '0;
      ihl_b   = '0;
      iplen_b = '0;
      ahi_b   = '0;
      alo_b   = '0;
      start_b = '0;
      end_b   = '0;
    end else begin
      pos_b   = pos_r;
      size_b  = size_r;
      phase_b = phase_r;
      etype_b = etype_r;
      ihl_b   = ihl_r;
      iplen_b = iplen_r;
      ahi_b   = ahi_r;
      alo_b   = alo_r;
      start_b = start_r;
      end_b   = end_r;
    end

    pos_nxt   = pos_b;
    size_nxt  = size_b;
    phase_nxt = phase_b;
    etype_nxt = etype_b;
    ihl_nxt   = ihl_b;
    iplen_nxt = iplen_b;
    ahi_nxt   = ahi_b;
    alo_nxt   = alo_b;
    start_nxt = start_b;
    end_nxt   = end_b;

    hit      = 1'b0;
    res_item = '0;
    st       = ST_OK;
    etype_c  = {etype_b[15:8], b};
    ihl_ext  = {9'd0, ihl_b};
    doff     = b[7:4];
    doff4    = {10'd0, doff, 2'b00};
    avail    = 16'(end_b - start_b);
    fin      = 1'b0;

    if (s1_item.frame_first && (s1_item.frame_size < MIN_FRAME)) begin
      phase_nxt = PH_IDLE;
      hit       = 1'b1;
      res_item  = mk_verdict(ST_SHORT, 1'b0, 1'b0, '0, '0, '0);
    end else if (phase_b != PH_IDLE) begin
      // source address capture
      if ((phase_b == PH_IP4) || (phase_b == PH_IP6) || (phase_b == PH_TCPHDR)) begin
        if ((etype_b == ETYPE_IP4) && (pos_b >= 17'd26) && (pos_b <= 17'd29)) begin
          alo_nxt = {32'd0, alo_b[23:0], b};
        end else if ((etype_b == ETYPE_IP6) && (pos_b >= 17'd22) && (pos_b <= 17'd37)) begin
          ahi_nxt = {ahi_b[55:0], alo_b[63:56]};
          alo_nxt = {alo_b[55:0], b};
        end
      end

      unique case (phase_b)
        PH_ETH: begin
          if (pos_b == 17'd12) begin
            etype_nxt = {b, 8'h00};
          end else if (pos_b == 17'd13) begin
            etype_nxt = etype_c;
            if (etype_c == ETYPE_IP4) begin
              phase_nxt = PH_IP4;
            end else if (etype_c == ETYPE_IP6) begin
              phase_nxt = PH_IP6;
            end else begin
              hit       = 1'b1;
              phase_nxt = PH_IDLE;
              res_item  = mk_verdict(ST_NOT_IP, 1'b0, 1'b0, '0, '0, '0);
            end
          end
        end
        PH_IP4: begin
          if (pos_b == 17'd14) begin
            ihl_nxt = {1'b0, b[3:0], 2'b00};
          end else if (pos_b == 17'd16) begin
            iplen_nxt = {b, 8'h00};
          end else if (pos_b == 17'd17) begin
            iplen_nxt = {iplen_b[15:8], b};
          end else if (pos_b == 17'd23) begin
            priority if (b != PROTO_TCP) begin
              st = ST_NOT_TCP;
            end else if ({1'b0, size_b} < (ETH_HDR + {1'b0, iplen_b})) begin
              st = ST_IP_LEN;
            end else if (ihl_ext < TCP_MIN) begin
              st = ST_BAD_HLEN;
            end else if (ihl_ext > iplen_b) begin
              st = ST_IHL_LEN;
            end else if ((iplen_b - ihl_ext) < TCP_MIN) begin
              st = ST_IP_PAY;
            end else begin
              st = ST_OK;
            end
            if (st != ST_OK) begin
              hit       = 1'b1;
              phase_nxt = PH_IDLE;
              res_item  = mk_verdict(st, 1'b0, 1'b0, '0, '0, '0);
            end else begin
              start_nxt = ETH_HDR + {10'd0, ihl_b};
              end_nxt   = ETH_HDR + {1'b0, iplen_b};
              phase_nxt = PH_TCPHDR;
            end
          end
        end
        PH_IP6: begin
          if (pos_b == 17'd18) begin
            iplen_nxt = {b, 8'h00};
          end else if (pos_b == 17'd19) begin
            iplen_nxt = {iplen_b[15:8], b};
          end else if (pos_b == 17'd20) begin
            priority if (b != PROTO_TCP) begin
              st = ST_NOT_TCP;
            end else if ({1'b0, size_b} < (ETH_IP6 + {1'b0, iplen_b})) begin
              st = ST_IP_LEN;
            end else if (iplen_b < TCP_MIN) begin
              st = ST_IP_PAY;
            end else begin
              st = ST_OK;
            end
            if (st != ST_OK) begin
              hit       = 1'b1;
              phase_nxt = PH_IDLE;
              res_item  = mk_verdict(st, 1'b1, 1'b0, '0, '0, '0);
            end else begin
              start_nxt = ETH_IP6;
              end_nxt   = ETH_IP6 + {1'b0, iplen_b};
              phase_nxt = PH_TCPHDR;
            end
          end
        end
        PH_TCPHDR: begin
          if (pos_b == (start_b + DOFF_OFS)) begin
            hit = 1'b1;
            priority if (doff < 4'd5) begin
              phase_nxt = PH_IDLE;
              res_item  = mk_verdict(ST_BAD_HLEN, etype_b == ETYPE_IP6, 1'b0, '0, '0, '0);
            end else if (doff4 > avail) begin
              phase_nxt = PH_IDLE;
              res_item  = mk_verdict(ST_TCP_HDR, etype_b == ETYPE_IP6, 1'b0, '0, '0, '0);
            end else begin
              res_item  = mk_verdict(ST_OK, etype_b == ETYPE_IP6, 1'b1, ahi_nxt, alo_nxt,
                                     16'(avail - doff4));
              start_nxt = start_b + {1'b0, doff4};
              phase_nxt = ((start_b + {1'b0, doff4}) == end_b) ? PH_IDLE : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if ((pos_b >= start_b) && (pos_b < end_b)) begin
            fin = (({1'b0, pos_b} + 18'd1) == {1'b0, end_b}) || s1_item.frame_last;
            hit = 1'b1;
            res_item.result_kind  = KIND_BYTE;
            res_item.payload_byte = b;
            res_item.payload_last = fin;
            if (fin) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      if (s1_item.frame_last) begin
        if (!hit && ((phase_nxt == PH_ETH) || (phase_nxt == PH_IP4) ||
                     (phase_nxt == PH_IP6) || (phase_nxt == PH_TCPHDR))) begin
          hit      = 1'b1;
          res_item = mk_verdict(ST_EARLY_END, etype_nxt == ETYPE_IP6, 1'b0, '0, '0, '0);
        end
        phase_nxt = PH_IDLE;
      end

      pos_nxt = (pos_b != POS_MAX) ? (pos_b + 17'd1) : pos_b;
    end
  end

  assign res_valid = s1_valid && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      size_r  <= '0;
      etype_r <= '0;
      ihl_r   <= '0;
      iplen_r <= '0;
      ahi_r   <= '0;
      alo_r   <= '0;
      start_r <= '0;
      end_r   <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      size_r  <= size_nxt;
      etype_r <= etype_nxt;
      ihl_r   <= ihl_nxt;
      iplen_r <= iplen_nxt;
      ahi_r   <= ahi_nxt;
      alo_r   <= alo_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

// ===== rtl/core/eitpe_out_stage.sv =====
// Result register stage
module eitpe_out_stage
  import eitpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_item_t res_item,
  output logic      advance,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t item_r;

  assign advance   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      item_r <= res_item;
    end
  end

endmodule

// ===== rtl/core/eth_ip_tcp_payload_extractor_core.sv =====
// Top level of the Ethernet/IPv4/IPv6 TCP payload extractor
//
//   channel  dir  handshake            item
//   in_      in   in_valid / in_stall  in_item_t  (one frame byte)
//   out_     out  out_valid / out_stall out_item_t (verdict or payload byte)
//
// One byte per clock sustained while out_stall is low; an accepted byte is held in the input register,
// and its result is loaded into the result register when advance is high, then offered on out_.
// The input register and the result register sit around the combinational parser.
// Synchronous active-low reset clears the parse phase and both stage valids.
// in_stall rises only while a result waits with out_stall high and an item is held.
module eth_ip_tcp_payload_extractor_core
  import eitpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      advance;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      res_valid;
  out_item_t res_item;

  eitpe_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  eitpe_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .advance   (advance),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  eitpe_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/eitpe_checker.sv =====
// Port-level checks for the payload extractor, bound to the top level
`include "eth_ip_tcp_payload_extractor_core_defines.svh"

module eitpe_checker
  import eitpe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `EITPE_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result valid straight after reset")

  `EITPE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result item changed")

  `EITPE_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

  `EITPE_ASSERT_NXT(a_short_frame, (in_valid && !in_stall && in_data.frame_first && (in_data.frame_size < MIN_FRAME)) ##1 !in_stall, out_valid && (out_data.result_kind == KIND_VERDICT) && (out_data.status == ST_SHORT), "short frame verdict missing")

endmodule

bind eth_ip_tcp_payload_extractor_core eitpe_checker u_eitpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
